// ----- rtl/qpht_pkg.sv -----
// Shared types, constants and codes for the quadratic probing hash table.
// Used by every module in the rtl folder; depends on nothing else.
package qpht_pkg;

    localparam int TABLE_SIZE  = 32;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W       = 31;
    localparam int LEN_W       = 6;
    localparam int SQ_W        = 11;
    localparam int REM_DIGIT_W = 4;
    localparam int REM_STEPS   = 8;
    localparam int REM_CNT_W   = $clog2(REM_STEPS);
    localparam int DIV_W       = REM_STEPS * REM_DIGIT_W;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_CHECK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       rem_start;
        logic       clear_all;
        logic       pos_init;
        logic       step;
        logic       wr_slot;
        logic       set_res;
        logic [2:0] res_status;
        logic       res_use_pos;
        logic       out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] in_opcode;
        logic [1:0] opcode;
        logic       rem_done;
        logic       slot_used;
        logic       key_match;
        logic       last_stage;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- rtl/quadratic_probe_hash_table.sv -----
// Top level of the quadratic probing hash table: controller, datapath, config register.
// Depends on qpht_pkg, qpht_ctrl and qpht_datapath.
//
//   Channel   Signals                        Direction   Payload
//   input     in_valid, in_stall, in_data    in          opcode, key
//   output    out_valid, out_stall, out_data out         status, slot_index
//   config    cfg_wr_en, cfg_wr_data         in          table_len
//
// An insert or search runs from acceptance to a loaded result through a wait on the
// four-bit-per-cycle remainder unit, then a probe and a check step for each of P probed
// slots (P is 1 to the table length; the check follows the registered key memory read),
// then a finish step. A clear or an unknown opcode goes from acceptance straight to the
// finish step. The next transaction can be accepted in the cycle after a result is loaded.
// Reset empties the table at once. A waiting result sits in the output register while
// the next transaction is processed; it only holds the finish step while out_stall is high.
module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    logic [LEN_W-1:0] table_len_reg;
    ctl_cmd_t         cmd;
    dp_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_len_reg <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            table_len_reg <= cfg_wr_data;
        end
    end

    qpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    qpht_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .table_len (table_len_reg),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("Input channel was not stalled after a transaction was accepted.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_slot |-> !stat.slot_used)
        else $error("Insert wrote into an occupied slot.");

    a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_FULL
            || out_data.status == ST_CLEARED)) |-> (out_data.slot_index == '0))
        else $error("Result without a slot carries a nonzero slot index.");
`endif

endmodule

// ----- rtl/qpht_rem.sv -----
// Iterative remainder unit: key modulo table length, four key bits per cycle.
// Depends on qpht_pkg.
module qpht_rem
    import qpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic              done,
    output logic [SLOT_W-1:0] remainder
);

    logic [DIV_W-1:0]     shift_reg, shift_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SLOT_W-1:0]    rem_step;

    always_comb
    begin
        logic [SLOT_W-1:0] r;
        logic [LEN_W-1:0]  t;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < REM_DIGIT_W; i++)
        begin
            t = {r, shift_reg[DIV_W-1-i]};
            if (t >= divisor)
            begin
                t = t - divisor;
            end
            r = t[SLOT_W-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = DIV_W'(dividend);
            rem_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << REM_DIGIT_W;
            rem_next   = rem_step;
            cnt_next   = cnt_reg + REM_CNT_W'(1);
            if (cnt_reg == REM_CNT_W'(REM_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/qpht_datapath.sv -----
// Datapath: slot key memory, occupancy flags, probe position and result register.
// Depends on qpht_pkg and instantiates qpht_rem.
module qpht_datapath
    import qpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] table_len,
    input  in_t              in_data,
    input  logic             out_stall,
    input  ctl_cmd_t         cmd,
    output dp_stat_t         stat,
    output logic             out_valid,
    output out_t             out_data
);

    logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
    logic [KEY_W-1:0]      rd_key_reg;
    logic [TABLE_SIZE-1:0] used_reg, used_next;
    logic [KEY_W-1:0]      key_reg;
    logic [1:0]            opcode_reg;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]      stage_reg, stage_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [2:0]            res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_data_reg;
    logic [LEN_W-1:0]      eff_len;
    logic [SQ_W-1:0]       pos_sum;
    logic                  rem_done;
    logic [SLOT_W-1:0]     rem_value;

    always_comb
    begin
        if (table_len == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (table_len > LEN_W'(TABLE_SIZE))
        begin
            eff_len = LEN_W'(TABLE_SIZE);
        end
        else
        begin
            eff_len = table_len;
        end
    end

    qpht_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rem_start),
        .dividend  (in_data.key),
        .divisor   (eff_len),
        .done      (rem_done),
        .remainder (rem_value)
    );

    assign pos_sum = SQ_W'(pos_reg) + sq_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        stage_next = stage_reg;
        sq_next    = sq_reg;
        if (cmd.pos_init)
        begin
            pos_next   = rem_value;
            stage_next = LEN_W'(1);
            sq_next    = SQ_W'(1);
        end
        else if (cmd.step)
        begin
            if (pos_sum >= SQ_W'(eff_len))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_sum[SLOT_W-1:0];
            end
            stage_next = stage_reg + LEN_W'(1);
            sq_next    = sq_reg + SQ_W'({stage_reg, 1'b1});
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.clear_all)
        begin
            used_next = '0;
        end
        else if (cmd.wr_slot)
        begin
            used_next[pos_reg] = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_slot)
        begin
            key_mem[pos_reg] <= key_reg;
        end
        rd_key_reg <= key_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        stage_reg <= stage_next;
        sq_reg    <= sq_next;
        if (cmd.load)
        begin
            key_reg    <= in_data.key;
            opcode_reg <= in_data.opcode;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cmd.res_use_pos ? pos_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_data_reg.status     <= res_status_reg;
            out_data_reg.slot_index <= res_slot_reg;
        end
    end

    assign stat.in_opcode  = in_data.opcode;
    assign stat.opcode     = opcode_reg;
    assign stat.rem_done   = rem_done;
    assign stat.slot_used  = used_reg[pos_reg];
    assign stat.key_match  = (rd_key_reg == key_reg);
    assign stat.last_stage = (stage_reg == eff_len);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/qpht_ctrl.sv -----
// Controller state machine that sequences remainder, probing and result hand-off.
// Depends on qpht_pkg.
module qpht_ctrl
    import qpht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  dp_stat_t stat,
    output logic     in_stall,
    output ctl_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.in_opcode inside {OP_INSERT, OP_SEARCH})
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_MOD:
            begin
                if (stat.rem_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.slot_used || stat.last_stage)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.opcode == OP_SEARCH && stat.key_match)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (stat.in_opcode)
                        OP_INSERT, OP_SEARCH:
                        begin
                            cmd.rem_start = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear_all  = 1'b1;
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_CLEARED;
                        end
                        default:
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                cmd.pos_init = stat.rem_done;
            end
            S_CHECK:
            begin
                if (stat.opcode == OP_INSERT)
                begin
                    if (!stat.slot_used)
                    begin
                        cmd.wr_slot     = 1'b1;
                        cmd.set_res     = 1'b1;
                        cmd.res_status  = ST_INSERTED;
                        cmd.res_use_pos = 1'b1;
                    end
                    else if (stat.last_stage)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
                else
                begin
                    if (!stat.slot_used)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                    end
                    else if (stat.key_match)
                    begin
                        cmd.set_res     = 1'b1;
                        cmd.res_status  = ST_FOUND;
                        cmd.res_use_pos = 1'b1;
                    end
                    else if (stat.last_stage)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
